// ===== rtl/core/color_key_run_extractor_core_assert.svh =====
// Assertion macros shared by the color key run extractor checkers.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef COLOR_KEY_RUN_EXTRACTOR_CORE_ASSERT_SVH
`define COLOR_KEY_RUN_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CKRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CKRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ckre_pkg.sv =====
// Shared types and constants for the color key run extractor.
// No dependencies; used by every module of the block.
package ckre_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned BATCH_RECTS = 2000;

  localparam int unsigned COORD_W   = 13;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [COORD_W-1:0] BOX_EMPTY   = '1;
  localparam logic [COORD_W-1:0] LAST_COLUMN = COORD_W'(MAX_WIDTH - 1);
  localparam logic [COORD_W-1:0] LAST_ROW    = COORD_W'(MAX_HEIGHT - 1);
  localparam logic [COUNT_W-1:0] BATCH_LIMIT = COUNT_W'(BATCH_RECTS);

  localparam logic [BYTE_W-1:0] KEY_RESET = 8'h00;
  localparam logic [BYTE_W-1:0] TOL_RESET = 8'h10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_BYTE0 = 3'd0,
    CFG_KEY_BYTE1 = 3'd1,
    CFG_KEY_BYTE2 = 3'd2,
    CFG_TOL_BYTE0 = 3'd3,
    CFG_TOL_BYTE1 = 3'd4,
    CFG_TOL_BYTE2 = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][BYTE_W-1:0] key;
    logic [NUM_CHAN-1:0][BYTE_W-1:0] tol;
  } key_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte0;
    logic [BYTE_W-1:0] pixel_byte1;
    logic [BYTE_W-1:0] pixel_byte2;
    logic              row_end;
    logic              image_end;
  } in_t;

  typedef struct packed {
    logic               rect_valid;
    logic [COORD_W-1:0] run_left;
    logic [COORD_W-1:0] run_top;
    logic [COORD_W-1:0] run_right;
    logic [COORD_W-1:0] run_bottom;
    logic               batch_end;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
    logic               image_done;
  } out_t;

  // Per-pixel status handed from the classifier to the run scanner.
  typedef struct packed {
    logic opaque;
    logic row_end;
    logic image_end;
  } px_class_t;

endpackage

// ===== rtl/core/ckre_classify.sv =====
// Color key compare: marks a pixel opaque unless every byte sits in its key band.
// Depends on ckre_pkg.
module ckre_classify (
  input  ckre_pkg::key_cfg_t  cfg,
  input  ckre_pkg::in_t       px,
  output ckre_pkg::px_class_t cls
);

  logic [ckre_pkg::NUM_CHAN-1:0][ckre_pkg::BYTE_W-1:0] chan;
  logic [ckre_pkg::NUM_CHAN-1:0]                       in_band;

  assign chan[0] = px.pixel_byte0;
  assign chan[1] = px.pixel_byte1;
  assign chan[2] = px.pixel_byte2;

  always_comb begin
    logic [ckre_pkg::BYTE_W:0]   sum;
    logic [ckre_pkg::BYTE_W-1:0] hi;
    for (int i = 0; i < int'(ckre_pkg::NUM_CHAN); i++) begin
      sum = {1'b0, cfg.key[i]} + {1'b0, cfg.tol[i]};
      // saturate the upper bound at the byte maximum
      hi = sum[ckre_pkg::BYTE_W] ? '1 : sum[ckre_pkg::BYTE_W-1:0];
      in_band[i] = (chan[i] >= cfg.key[i]) && (chan[i] <= hi);
    end
  end

  assign cls.opaque    = ~&in_band;
  assign cls.row_end   = px.row_end;
  assign cls.image_end = px.image_end;

endmodule

// ===== rtl/core/ckre_scan.sv =====
// Run scanner: raster position, open run, batch bounding box and result forming.
// Depends on ckre_pkg; fed by ckre_classify.
module ckre_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ckre_pkg::px_class_t cls,
  output logic                res_valid,
  output ckre_pkg::out_t      res
);

  logic [ckre_pkg::COORD_W-1:0] column_r, column_nxt;
  logic [ckre_pkg::COORD_W-1:0] row_r, row_nxt;
  logic                         run_open_r, run_open_nxt;
  logic [ckre_pkg::COORD_W-1:0] run_start_r, run_start_nxt;
  logic [ckre_pkg::COORD_W-1:0] bound_left_r, bound_left_nxt;
  logic [ckre_pkg::COORD_W-1:0] bound_top_r, bound_top_nxt;
  logic [ckre_pkg::COORD_W-1:0] bound_right_r, bound_right_nxt;
  logic [ckre_pkg::COORD_W-1:0] bound_bottom_r, bound_bottom_nxt;
  logic [ckre_pkg::COUNT_W-1:0] batch_count_r, batch_count_nxt;

  logic                         eol, eoi, opens, emit, close_batch;
  logic [ckre_pkg::COORD_W-1:0] rl, rt, rr, rb;
  logic [ckre_pkg::COORD_W-1:0] new_left, new_top, new_right, new_bottom;
  logic [ckre_pkg::COUNT_W-1:0] count_inc;

  always_comb begin
    eol   = cls.row_end || cls.image_end || (column_r >= ckre_pkg::LAST_COLUMN);
    eoi   = cls.image_end || (eol && (row_r >= ckre_pkg::LAST_ROW));
    opens = cls.opaque && !run_open_r;
    // an opaque pixel at row end closes the run including itself
    emit  = (cls.opaque && eol) || (!cls.opaque && run_open_r);

    rl = opens ? column_r : run_start_r;
    rt = row_r;
    rr = cls.opaque ? column_r + 1'b1 : column_r;
    rb = row_r + 1'b1;

    new_left   = (emit && rl < bound_left_r)   ? rl : bound_left_r;
    new_top    = (emit && rt < bound_top_r)    ? rt : bound_top_r;
    new_right  = (emit && rr > bound_right_r)  ? rr : bound_right_r;
    new_bottom = (emit && rb > bound_bottom_r) ? rb : bound_bottom_r;

    count_inc   = batch_count_r + 1'b1;
    close_batch = emit && (count_inc >= ckre_pkg::BATCH_LIMIT);

    res_valid      = emit || eoi;
    res.rect_valid = emit;
    res.run_left   = emit ? rl : '0;
    res.run_top    = emit ? rt : '0;
    res.run_right  = emit ? rr : '0;
    res.run_bottom = emit ? rb : '0;
    res.batch_end  = close_batch || eoi;
    res.box_left   = new_left;
    res.box_top    = new_top;
    res.box_right  = new_right;
    res.box_bottom = new_bottom;
    res.image_done = eoi;

    column_nxt       = eol ? '0 : column_r + 1'b1;
    row_nxt          = eol ? row_r + 1'b1 : row_r;
    run_open_nxt     = (run_open_r || opens) && !emit && !eol;
    run_start_nxt    = opens ? column_r : run_start_r;
    bound_left_nxt   = new_left;
    bound_top_nxt    = new_top;
    bound_right_nxt  = new_right;
    bound_bottom_nxt = new_bottom;
    batch_count_nxt  = emit ? count_inc : batch_count_r;

    // drop the box once its batch is closed
    if (close_batch || eoi) begin
      bound_left_nxt   = ckre_pkg::BOX_EMPTY;
      bound_top_nxt    = ckre_pkg::BOX_EMPTY;
      bound_right_nxt  = '0;
      bound_bottom_nxt = '0;
      batch_count_nxt  = '0;
    end
    if (eoi) begin
      column_nxt    = '0;
      row_nxt       = '0;
      run_open_nxt  = 1'b0;
      run_start_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r       <= '0;
      row_r          <= '0;
      run_open_r     <= 1'b0;
      run_start_r    <= '0;
      bound_left_r   <= ckre_pkg::BOX_EMPTY;
      bound_top_r    <= ckre_pkg::BOX_EMPTY;
      bound_right_r  <= '0;
      bound_bottom_r <= '0;
      batch_count_r  <= '0;
    end else if (fire) begin
      column_r       <= column_nxt;
      row_r          <= row_nxt;
      run_open_r     <= run_open_nxt;
      run_start_r    <= run_start_nxt;
      bound_left_r   <= bound_left_nxt;
      bound_top_r    <= bound_top_nxt;
      bound_right_r  <= bound_right_nxt;
      bound_bottom_r <= bound_bottom_nxt;
      batch_count_r  <= batch_count_nxt;
    end
  end

endmodule

// ===== rtl/core/color_key_run_extractor_core.sv =====
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    ckre_pkg::in_t, one pixel
// out_     output     out_valid/out_ready  ckre_pkg::out_t, one run or batch result
// cfg_     input      cfg_valid/cfg_ready  cfg_index (3 bits), cfg_data (8 bits)
//
// One pixel per cycle unless a stalled output holds the input register: a pixel
// is held in the input register, is classified and scanned, and its result (if
// any) lands in the output register. rst_n is synchronous; the block takes
// pixels from the cycle in which reset is released. A stalled output holds the
// input register only when the waiting pixel also has a result.
// Top level of the color key run extractor; depends on ckre_pkg,
// ckre_classify and ckre_scan.
module color_key_run_extractor_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ckre_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ckre_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ckre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ckre_pkg::BYTE_W-1:0]       cfg_data
);

  ckre_pkg::key_cfg_t  cfg_r, cfg_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  ckre_pkg::in_t       s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  ckre_pkg::out_t      out_data_r;
  ckre_pkg::px_class_t cls;
  ckre_pkg::out_t      res;
  logic                res_valid, s1_adv, in_fire;

  assign cfg_ready = rst_n;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (ckre_pkg::cfg_index_t'(cfg_index))
        ckre_pkg::CFG_KEY_BYTE0: cfg_nxt.key[0] = cfg_data;
        ckre_pkg::CFG_KEY_BYTE1: cfg_nxt.key[1] = cfg_data;
        ckre_pkg::CFG_KEY_BYTE2: cfg_nxt.key[2] = cfg_data;
        ckre_pkg::CFG_TOL_BYTE0: cfg_nxt.tol[0] = cfg_data;
        ckre_pkg::CFG_TOL_BYTE1: cfg_nxt.tol[1] = cfg_data;
        ckre_pkg::CFG_TOL_BYTE2: cfg_nxt.tol[2] = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  ckre_classify u_classify (
    .cfg (cfg_r),
    .px  (s1_data_r),
    .cls (cls)
  );

  ckre_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_adv),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res)
  );

  // advance unless the pixel has a result and the output slot stays full
  assign s1_adv   = s1_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready = rst_n && (!s1_valid_r || s1_adv);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key   <= {ckre_pkg::NUM_CHAN{ckre_pkg::KEY_RESET}};
      cfg_r.tol   <= {ckre_pkg::NUM_CHAN{ckre_pkg::TOL_RESET}};
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/ckre_checker.sv =====
// Port-level checks for the color key run extractor, bound to the top level.
// Depends on ckre_pkg and color_key_run_extractor_core_assert.svh.
`include "color_key_run_extractor_core_assert.svh"

module ckre_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ckre_pkg::out_t out_data
);

  // hold a stalled transaction
  `CKRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // a fresh result follows a taken pixel that passed through the input register
  `CKRE_ASSERT_NOW(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "result without pixel")

  `CKRE_ASSERT_NOW(a_quiet_is_image_end, out_valid && !out_data.rect_valid, out_data.image_done && out_data.batch_end, "empty result not at image end")

  `CKRE_ASSERT_NOW(a_run_in_box, out_valid && out_data.rect_valid, (out_data.run_bottom == out_data.run_top + 13'd1) && (out_data.run_right > out_data.run_left) && (out_data.box_left <= out_data.run_left) && (out_data.box_right >= out_data.run_right), "run shape or box wrong")

endmodule

bind color_key_run_extractor_core ckre_checker u_ckre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
